// File: hdl/fatigue_risk_classifier_defines.svh
// Assertion macros for the fatigue risk classifier.
// No dependencies; included by the checker.
`ifndef FATIGUE_RISK_CLASSIFIER_DEFINES_SVH
`define FATIGUE_RISK_CLASSIFIER_DEFINES_SVH
// Assert an implication on the clock with reset disabled.
`define FRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fatigue risk check failed");
// Assert a condition on the next cycle.
`define FRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fatigue risk check failed");
`endif

// File: hdl/frc_pkg.sv
// Package for the fatigue risk classifier: payload types, register indexes, constants.
// No dependencies.
package frc_pkg;
    localparam int RING_DEPTH_DEF = 64;
    localparam int CFG_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam logic [9:0] MS_PER_SEC = 10'd1000;
    localparam logic [6:0] SCORE_MAX = 7'd100;

    // Elapsed time at or above this gives a decay quotient that empties any score
    localparam logic [47:0] DECAY_SAT_MS = 48'd2048000;
    // ceil(2^25 / 125): exact floor(x / 125) for any x below 2^18
    localparam logic [18:0] RECIP_125 = 19'd268436;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LC_WARN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HD_WARN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REC_HOLD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS   = 3'd6;

    localparam logic [19:0] SHORT_WIN_RST = 20'd60000;
    localparam logic [19:0] LONG_WIN_RST  = 20'd300000;
    localparam logic [15:0] LC_WARN_RST   = 16'd1500;
    localparam logic [15:0] HD_WARN_RST   = 16'd3000;
    localparam logic [15:0] REC_HOLD_RST  = 16'd5000;
    localparam logic [47:0] THRESH_RST    = 48'd2233467011841;
    localparam logic [47:0] WEIGHTS_RST   = 48'd2242225248517;

    // Ring kind codes
    localparam logic [1:0] KIND_CLOSURE = 2'd0;
    localparam logic [1:0] KIND_LONG    = 2'd1;
    localparam logic [1:0] KIND_YAWN    = 2'd2;
    localparam logic [1:0] KIND_HEAD    = 2'd3;

    // Output event codes
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_CLOSURE = 3'd1;
    localparam logic [2:0] EV_LONG = 3'd2;
    localparam logic [2:0] EV_YAWN = 3'd3;
    localparam logic [2:0] EV_HEAD = 3'd4;
    localparam logic [2:0] EV_FACE_LOST = 3'd5;
    localparam logic [2:0] EV_COMBO = 3'd6;

    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_ATTN = 2'd1;
    localparam logic [1:0] LVL_WARN = 2'd2;
    localparam logic [1:0] LVL_HIGH = 2'd3;

    typedef struct packed {
        logic [47:0] frame_time_ms;
        logic        eyes_shut;
        logic        eyes_shut_long;
        logic        yawn;
        logic        head_low;
        logic        face_seen;
        logic [23:0] closure_duration_ms;
        logic [23:0] long_closure_duration_ms;
        logic [23:0] yawn_len_ms;
        logic [23:0] head_low_len_ms;
    } frc_in_t;

    typedef struct packed {
        logic [1:0]  risk_level;
        logic [6:0]  fatigue_score;
        logic [2:0]  event_kind;
        logic [23:0] event_len_ms;
        logic        alarm_request;
        logic        save_request;
    } frc_out_t;

    // Push and scan request from sequencer to ring unit
    typedef struct packed {
        logic        push;
        logic [1:0]  push_kind;
        logic        scan_start;
        logic [47:0] cut_short;
        logic [47:0] cut_long;
    } frc_ring_cmd_t;

    function automatic logic [7:0] byte_of(input logic [47:0] r, input int k);
        byte_of = r[8*k +: 8];
    endfunction
endpackage

// File: hdl/fatigue_risk_classifier.sv
// Fatigue risk classifier. One frame is taken at a time. Each frame pushes up
// to four events into the ring (one per cycle), then scans all filled ring
// entries at one entry per cycle, then divides the decay interval by 1000 with
// a shift and a reciprocal multiply and settles the level. The ring scan is the
// part of a frame whose length grows with the ring fill. The result register
// holds the result until taken while the next frame is already accepted and
// worked on; a frame waits in its last step only while the previous result is
// untaken.
// Depends on frc_pkg and frc_ring.
module fatigue_risk_classifier #(
    parameter int RING_DEPTH = frc_pkg::RING_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [frc_pkg::CFG_W-1:0] cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  frc_pkg::frc_in_t       s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output frc_pkg::frc_out_t      m_data
);
    import frc_pkg::*;
    localparam int CW = $clog2(RING_DEPTH+1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PUSH, ST_SCAN, ST_WAIT, ST_DIV, ST_FINISH, ST_OUT
    } state_t;

    // Configuration registers
    logic [19:0] sw_reg, lw_reg;
    logic [15:0] lcw_reg, hdw_reg, rh_reg;
    logic [47:0] th_reg, wt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= SHORT_WIN_RST; lw_reg <= LONG_WIN_RST;
            lcw_reg <= LC_WARN_RST; hdw_reg <= HD_WARN_RST; rh_reg <= REC_HOLD_RST;
            th_reg <= THRESH_RST; wt_reg <= WEIGHTS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SHORT_WIN: sw_reg <= cfg_data[19:0];
                REG_LONG_WIN:  lw_reg <= cfg_data[19:0];
                REG_LC_WARN:   lcw_reg <= cfg_data[15:0];
                REG_HD_WARN:   hdw_reg <= cfg_data[15:0];
                REG_REC_HOLD:  rh_reg <= cfg_data[15:0];
                REG_THRESH:    th_reg <= cfg_data;
                REG_WEIGHTS:   wt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg;
    frc_in_t fr_reg;
    logic [3:0] prev_reg, rise_reg;
    logic [1:0] pcnt_reg;
    logic [10:0] s_reg;          // working score
    logic [6:0] score_reg;
    logic [1:0] held_reg;
    logic       rec_reg;
    logic [47:0] rec_t_reg, dec_t_reg;
    logic [47:0] el_reg;
    logic [10:0] quo_reg;
    logic [47:0] cs_reg, cl_reg;
    logic        ring_push;
    logic [1:0]  ring_kind;
    logic        scan_start_reg;
    logic        m_valid_reg;
    frc_out_t    out_reg;
    frc_ring_cmd_t cmd;
    logic        scan_done;
    logic [CW-1:0] lcs, yws, ywl, tot;
    logic [2:0]  kinds;

    // Rising edges; a closure during a long closure is not pushed
    logic [3:0] push_mask;
    assign push_mask = {rise_reg[3:1], rise_reg[0] & ~fr_reg.eyes_shut_long};
    always_comb begin
        ring_push = (state_reg == ST_PUSH) && push_mask[pcnt_reg];
        ring_kind = pcnt_reg;
    end

    assign cmd = '{push: ring_push, push_kind: ring_kind, scan_start: scan_start_reg,
                   cut_short: cs_reg, cut_long: cl_reg};

    frc_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .now(fr_reg.frame_time_ms),
        .scan_done(scan_done), .lc_short(lcs), .yawn_short(yws), .yawn_long(ywl),
        .all_long(tot), .kinds_short(kinds)
    );

    // Level decision from tallies and flags
    logic [1:0] raw;
    logic combo_met;
    assign combo_met = 8'(kinds) >= byte_of(th_reg, 5);
    always_comb begin
        if (9'(lcs) >= 9'(byte_of(th_reg, 2))) raw = LVL_HIGH;
        else if (11'(tot) >= 11'(byte_of(th_reg, 4))) raw = LVL_HIGH;
        else if (fr_reg.eyes_shut_long && fr_reg.long_closure_duration_ms >= 24'(lcw_reg))
            raw = LVL_WARN;
        else if (fr_reg.head_low && fr_reg.head_low_len_ms >= 24'(hdw_reg))
            raw = LVL_WARN;
        else if (11'(yws) >= 11'(byte_of(th_reg, 1))) raw = LVL_WARN;
        else if (11'(ywl) >= 11'(byte_of(th_reg, 3))) raw = LVL_WARN;
        else if (combo_met) raw = LVL_WARN;
        else if (11'(yws) >= 11'(byte_of(th_reg, 0))) raw = LVL_ATTN;
        else if (fr_reg.eyes_shut_long || fr_reg.eyes_shut || fr_reg.head_low)
            raw = LVL_ATTN;
        else raw = LVL_NORMAL;
    end

    logic [47:0] el_dec, el_rec;
    assign el_dec = (fr_reg.frame_time_ms >= dec_t_reg) ?
                    fr_reg.frame_time_ms - dec_t_reg : '0;
    assign el_rec = (fr_reg.frame_time_ms >= rec_t_reg) ?
                    fr_reg.frame_time_ms - rec_t_reg : '0;

    // Whole seconds: divide by 8, then multiply by the reciprocal of 125
    logic [36:0] recip_prod;
    assign recip_prod = el_reg[20:3] * RECIP_125;

    // Decay amount: quotient times weight, saturated
    logic [18:0] dec_full;
    logic [10:0] s_dec, s_clamp;
    assign dec_full = quo_reg * byte_of(wt_reg, 5);
    assign s_dec = (dec_full >= 19'(s_reg)) ? '0 : s_reg - dec_full[10:0];

    logic [1:0] fin;
    logic rec_n;
    logic [47:0] rec_t_n;
    logic [2:0] kind;
    logic [23:0] dur;
    always_comb begin
        rec_n = rec_reg; rec_t_n = rec_t_reg; fin = held_reg;
        if (raw >= held_reg) begin
            rec_n = 1'b0; fin = raw;
        end else if (!rec_reg) begin
            rec_n = 1'b1; rec_t_n = fr_reg.frame_time_ms;
        end else if (el_rec >= 48'(rh_reg)) begin
            rec_n = 1'b0; fin = raw;
        end
        if (fin == LVL_NORMAL) kind = EV_NONE;
        else if (fr_reg.eyes_shut_long) kind = EV_LONG;
        else if (fr_reg.head_low) kind = EV_HEAD;
        else if (fr_reg.yawn) kind = EV_YAWN;
        else if (fr_reg.eyes_shut) kind = EV_CLOSURE;
        else if (!fr_reg.face_seen) kind = EV_FACE_LOST;
        else if (lcs != '0 && yws != '0) kind = EV_COMBO;
        else if (lcs != '0) kind = EV_LONG;
        else if (yws != '0) kind = EV_YAWN;
        else kind = EV_COMBO;
        if (fr_reg.eyes_shut_long) dur = fr_reg.long_closure_duration_ms;
        else if (fr_reg.head_low) dur = fr_reg.head_low_len_ms;
        else if (fr_reg.yawn) dur = fr_reg.yawn_len_ms;
        else if (fr_reg.eyes_shut) dur = fr_reg.closure_duration_ms;
        else dur = '0;
    end

    logic [3:0] flags_in;
    assign flags_in = {s_data.head_low, s_data.yawn, s_data.eyes_shut_long, s_data.eyes_shut};
    logic [10:0] w_add;
    assign w_add = push_mask[pcnt_reg] ? 11'(byte_of(wt_reg, int'(pcnt_reg))) : '0;
    assign s_clamp = (s_reg > 11'(SCORE_MAX)) ? 11'(SCORE_MAX) : s_reg;

    // Load the result register once the previous result is gone
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prev_reg <= '0; score_reg <= '0; held_reg <= LVL_NORMAL;
            rec_reg <= 1'b0; rec_t_reg <= '0; dec_t_reg <= '0;
            m_valid_reg <= 1'b0; scan_start_reg <= 1'b0;
        end else begin
            scan_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    fr_reg <= s_data;
                    rise_reg <= flags_in & ~prev_reg;
                    prev_reg <= flags_in;
                    pcnt_reg <= '0;
                    s_reg <= 11'(score_reg);
                    cs_reg <= (s_data.frame_time_ms > 48'(sw_reg)) ?
                              s_data.frame_time_ms - 48'(sw_reg) : '0;
                    cl_reg <= (s_data.frame_time_ms > 48'(lw_reg)) ?
                              s_data.frame_time_ms - 48'(lw_reg) : '0;
                    state_reg <= ST_PUSH;
                end
                // Push one event per cycle, add its weight
                ST_PUSH: begin
                    s_reg <= s_reg + w_add;
                    pcnt_reg <= pcnt_reg + 1'b1;
                    if (pcnt_reg == 2'd3) begin
                        scan_start_reg <= 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: state_reg <= ST_WAIT;
                ST_WAIT: if (scan_done) begin
                    if (combo_met && rise_reg != '0) s_reg <= s_reg + 11'(byte_of(wt_reg, 4));
                    el_reg <= el_dec;
                    state_reg <= ST_DIV;
                end
                // Whole seconds elapsed; saturate where any score would empty
                ST_DIV: begin
                    quo_reg <= (el_reg >= DECAY_SAT_MS) ? '1 : recip_prod[35:25];
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (dec_t_reg == '0) dec_t_reg <= fr_reg.frame_time_ms;
                    else if (quo_reg != '0) begin
                        s_reg <= s_dec;
                        dec_t_reg <= fr_reg.frame_time_ms;
                    end
                    state_reg <= ST_OUT;
                end
                // Hold the frame until the result register is free
                ST_OUT: if (out_load) begin
                    score_reg <= s_clamp[6:0];
                    held_reg <= fin; rec_reg <= rec_n; rec_t_reg <= rec_t_n;
                    out_reg <= '{risk_level: fin, fatigue_score: s_clamp[6:0],
                                 event_kind: kind, event_len_ms: dur,
                                 alarm_request: fin >= LVL_WARN,
                                 save_request: fin >= LVL_ATTN};
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;
endmodule

// File: hdl/frc_ring.sv
// Event ring and window scanner: one entry compared per cycle.
// Depends on frc_pkg.
module frc_ring #(
    parameter int RING_DEPTH = frc_pkg::RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  frc_pkg::frc_ring_cmd_t cmd,
    input  logic [47:0]           now,
    output logic                  scan_done,
    output logic [$clog2(RING_DEPTH+1)-1:0] lc_short,
    output logic [$clog2(RING_DEPTH+1)-1:0] yawn_short,
    output logic [$clog2(RING_DEPTH+1)-1:0] yawn_long,
    output logic [$clog2(RING_DEPTH+1)-1:0] all_long,
    output logic [2:0]            kinds_short
);
    import frc_pkg::*;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH+1);

    logic [47:0] times_mem [RING_DEPTH];
    logic [1:0]  types_mem [RING_DEPTH];
    logic [AW-1:0] wptr_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] idx_reg;
    logic          busy_reg, rd_v_reg, done_reg;
    logic [47:0]   rd_t_reg;
    logic [1:0]    rd_k_reg;
    logic [3:0]    seen_reg;
    logic [CW-1:0] lcs_reg, yws_reg, ywl_reg, tot_reg;

    // Write and read the ring in a clocked block
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            times_mem[wptr_reg] <= now;
            types_mem[wptr_reg] <= cmd.push_kind;
        end
        rd_t_reg <= times_mem[idx_reg[AW-1:0]];
        rd_k_reg <= types_mem[idx_reg[AW-1:0]];
    end

    logic in_s, in_l;
    assign in_s = rd_t_reg >= cmd.cut_short;
    assign in_l = rd_t_reg >= cmd.cut_long;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            fill_reg <= '0;
            busy_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.push) begin
                wptr_reg <= (wptr_reg == AW'(RING_DEPTH-1)) ? '0 : wptr_reg + 1'b1;
                if (fill_reg != CW'(RING_DEPTH)) fill_reg <= fill_reg + 1'b1;
            end
            // Issue one read per cycle over the filled entries
            rd_v_reg <= busy_reg && (idx_reg < fill_reg);
            if (cmd.scan_start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                seen_reg <= '0;
                lcs_reg <= '0; yws_reg <= '0; ywl_reg <= '0; tot_reg <= '0;
            end else if (busy_reg) begin
                if (idx_reg < fill_reg) idx_reg <= idx_reg + 1'b1;
                else if (!rd_v_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            // Accumulate the tallies from the registered read
            if (rd_v_reg && !cmd.scan_start) begin
                if (in_s) begin
                    if (rd_k_reg == KIND_LONG) lcs_reg <= lcs_reg + 1'b1;
                    if (rd_k_reg == KIND_YAWN) yws_reg <= yws_reg + 1'b1;
                    seen_reg[rd_k_reg] <= 1'b1;
                end
                if (in_l) begin
                    tot_reg <= tot_reg + 1'b1;
                    if (rd_k_reg == KIND_YAWN) ywl_reg <= ywl_reg + 1'b1;
                end
            end
        end
    end

    assign scan_done = done_reg;
    assign lc_short = lcs_reg;
    assign yawn_short = yws_reg;
    assign yawn_long = ywl_reg;
    assign all_long = tot_reg;
    assign kinds_short = 3'($countones(seen_reg));
endmodule

// File: hdl/frc_checker.sv
// Port checker for the fatigue risk classifier, bound to the top level.
// Depends on frc_pkg and fatigue_risk_classifier_defines.svh.
`include "fatigue_risk_classifier_defines.svh"
module frc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input frc_pkg::frc_out_t m_data
);
    import frc_pkg::*;
    // Hold a stalled result
    `FRC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // Alarm and save flags follow the level
    `FRC_ASSERT_IMP(a_flags, m_valid, (m_data.alarm_request == (m_data.risk_level >= LVL_WARN))
        && (m_data.save_request == (m_data.risk_level != LVL_NORMAL)))
    // Score stays clamped
    `FRC_ASSERT_IMP(a_score, m_valid, m_data.fatigue_score <= SCORE_MAX)
    // No event kind exactly when the level is normal
    `FRC_ASSERT_IMP(a_kind, m_valid, (m_data.risk_level == LVL_NORMAL)
        == (m_data.event_kind == EV_NONE))
    // A transfer in makes the block busy next cycle
    `FRC_ASSERT_NEXT(a_seq, s_valid && s_ready, !s_ready)
endmodule

bind fatigue_risk_classifier frc_checker u_frc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// File: sim/tb_fatigue_risk_classifier.sv
// Self-checking testbench for the fatigue risk classifier: frames go in over a
// valid/ready channel, each result is checked against an in-bench classifier.
// Depends on frc_pkg and the fatigue_risk_classifier RTL.
`timescale 1ns / 100ps

module tb_fatigue_risk_classifier;
    import frc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RING_N = 64;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    frc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    frc_out_t m_data;

    fatigue_risk_classifier u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Classifier copy: configuration
    logic [19:0] win_short, win_long;
    logic [15:0] lc_warn, hd_warn, hold_ms;
    logic [47:0] thr_reg, wgt_reg;
    // Classifier copy: state
    logic [47:0] ring_time [RING_N];
    logic [1:0]  ring_kind [RING_N];
    int          wr_ptr, fill_cnt;
    logic [1:0]  held_lvl;
    logic [63:0] score_acc;
    bit          recov;
    logic [47:0] rec_start, last_decay;
    logic [3:0]  prev_flags;

    frc_in_t  frame_q[$];
    frc_out_t result_q[$];
    int       err_cnt = 0;
    logic [47:0] ts_now;

    function automatic logic [7:0] thr_byte(int k);
        return thr_reg[8*k +: 8];
    endfunction

    function automatic logic [7:0] wgt_byte(int k);
        return wgt_reg[8*k +: 8];
    endfunction

    task automatic record_event(logic [1:0] kind, logic [47:0] t);
        ring_time[wr_ptr] = t;
        ring_kind[wr_ptr] = kind;
        wr_ptr = (wr_ptr + 1) % RING_N;
        if (fill_cnt < RING_N) fill_cnt++;
    endtask

    task automatic classify_frame(input frc_in_t f, output frc_out_t r);
        logic [63:0] now, s, cs, cl, el, dec;
        logic re, rl, ry, rh;
        int lc_s, yw_s, yw_l, tot_l, kinds;
        bit seen [4];
        logic [1:0] raw, fin;
        logic [2:0] kind;
        logic [23:0] dur;
        now = f.frame_time_ms;
        re = f.eyes_shut && !prev_flags[0];
        rl = f.eyes_shut_long && !prev_flags[1];
        ry = f.yawn && !prev_flags[2];
        rh = f.head_low && !prev_flags[3];
        s = score_acc;
        // Record rising edges; closure under a long closure is not stored
        if (re && !f.eyes_shut_long) begin
            record_event(KIND_CLOSURE, now); s += wgt_byte(0);
        end
        if (rl) begin record_event(KIND_LONG, now); s += wgt_byte(1); end
        if (ry) begin record_event(KIND_YAWN, now); s += wgt_byte(2); end
        if (rh) begin record_event(KIND_HEAD, now); s += wgt_byte(3); end
        // Tally the windows
        cs = (now > win_short) ? now - win_short : 0;
        cl = (now > win_long) ? now - win_long : 0;
        lc_s = 0; yw_s = 0; yw_l = 0; tot_l = 0; kinds = 0;
        seen = '{default: 0};
        for (int i = 0; i < fill_cnt; i++) begin
            if (ring_time[i] >= cs) begin
                if (ring_kind[i] == KIND_LONG) lc_s++;
                if (ring_kind[i] == KIND_YAWN) yw_s++;
                if (!seen[ring_kind[i]]) begin seen[ring_kind[i]] = 1; kinds++; end
            end
            if (ring_time[i] >= cl) begin
                tot_l++;
                if (ring_kind[i] == KIND_YAWN) yw_l++;
            end
        end
        if (kinds >= thr_byte(5) && (re || rl || ry || rh)) s += wgt_byte(4);
        prev_flags = {f.head_low, f.yawn, f.eyes_shut_long, f.eyes_shut};
        // Decay per whole second; the first nonzero frame only starts the timer
        if (last_decay == 0) begin
            last_decay = now;
        end else begin
            el = (now >= last_decay) ? now - last_decay : 0;
            if (el >= MS_PER_SEC) begin
                dec = (el / MS_PER_SEC) * wgt_byte(5);
                s = (dec >= s) ? 0 : s - dec;
                last_decay = now;
            end
        end
        if (s > SCORE_MAX) s = SCORE_MAX;
        score_acc = s;
        // Raw level in priority order
        if (lc_s >= thr_byte(2)) raw = LVL_HIGH;
        else if (tot_l >= thr_byte(4)) raw = LVL_HIGH;
        else if (f.eyes_shut_long && f.long_closure_duration_ms >= lc_warn) raw = LVL_WARN;
        else if (f.head_low && f.head_low_len_ms >= hd_warn) raw = LVL_WARN;
        else if (yw_s >= thr_byte(1)) raw = LVL_WARN;
        else if (yw_l >= thr_byte(3)) raw = LVL_WARN;
        else if (kinds >= thr_byte(5)) raw = LVL_WARN;
        else if (yw_s >= thr_byte(0)) raw = LVL_ATTN;
        else if (f.eyes_shut_long || f.eyes_shut || f.head_low) raw = LVL_ATTN;
        else raw = LVL_NORMAL;
        // Upgrade at once, hold downgrades
        if (raw >= held_lvl) begin
            recov = 0; fin = raw;
        end else if (!recov) begin
            recov = 1; rec_start = now; fin = held_lvl;
        end else begin
            el = (now >= rec_start) ? now - rec_start : 0;
            if (el >= hold_ms) begin recov = 0; fin = raw; end
            else fin = held_lvl;
        end
        held_lvl = fin;
        if (fin == LVL_NORMAL) kind = EV_NONE;
        else if (f.eyes_shut_long) kind = EV_LONG;
        else if (f.head_low) kind = EV_HEAD;
        else if (f.yawn) kind = EV_YAWN;
        else if (f.eyes_shut) kind = EV_CLOSURE;
        else if (!f.face_seen) kind = EV_FACE_LOST;
        else if (lc_s > 0 && yw_s > 0) kind = EV_COMBO;
        else if (lc_s > 0) kind = EV_LONG;
        else if (yw_s > 0) kind = EV_YAWN;
        else kind = EV_COMBO;
        if (f.eyes_shut_long) dur = f.long_closure_duration_ms;
        else if (f.head_low) dur = f.head_low_len_ms;
        else if (f.yawn) dur = f.yawn_len_ms;
        else if (f.eyes_shut) dur = f.closure_duration_ms;
        else dur = '0;
        r.risk_level = fin;
        r.fatigue_score = s[6:0];
        r.event_kind = kind;
        r.event_len_ms = dur;
        r.alarm_request = (fin >= LVL_WARN);
        r.save_request = (fin >= LVL_ATTN);
    endtask

    task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        err_cnt++;
    endtask

    // Driver: bursts of transfers separated by random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        frc_out_t r;
        if (s_valid && s_ready) begin
            classify_frame(s_data, r);
            result_q.push_back(r);
        end
        if (!(s_valid && !s_ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                s_data <= frame_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result; the receiver stalls in randomly chosen modes
    int stall_mode = 0, mode_cnt = 0, stall_left = 0;
    always @(posedge aclk) begin
        frc_out_t want;
        if (m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                if (m_data.risk_level !== want.risk_level)
                    report_mismatch("risk_level", m_data.risk_level, want.risk_level);
                if (m_data.fatigue_score !== want.fatigue_score)
                    report_mismatch("fatigue_score", m_data.fatigue_score, want.fatigue_score);
                if (m_data.event_kind !== want.event_kind)
                    report_mismatch("event_kind", m_data.event_kind, want.event_kind);
                if (m_data.event_len_ms !== want.event_len_ms)
                    report_mismatch("event_len_ms", m_data.event_len_ms,
                                    want.event_len_ms);
                if (m_data.alarm_request !== want.alarm_request)
                    report_mismatch("alarm_request", m_data.alarm_request, want.alarm_request);
                if (m_data.save_request !== want.save_request)
                    report_mismatch("save_request", m_data.save_request, want.save_request);
            end
        end
        if (mode_cnt == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_cnt <= $urandom_range(100, 600);
        end else begin
            mode_cnt <= mode_cnt - 1;
        end
        if (stall_mode == 0) begin
            m_ready <= 1'b1;
        end else if (stall_mode == 1) begin
            m_ready <= 1'($urandom_range(0, 1));
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : 0;
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SHORT_WIN: win_short = val[19:0];
            REG_LONG_WIN:  win_long = val[19:0];
            REG_LC_WARN:   lc_warn = val[15:0];
            REG_HD_WARN:   hd_warn = val[15:0];
            REG_REC_HOLD:  hold_ms = val[15:0];
            REG_THRESH:    thr_reg = val;
            REG_WEIGHTS:   wgt_reg = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [47:0] sw, logic [47:0] lw, logic [47:0] lcw,
                             logic [47:0] hdw, logic [47:0] rh, logic [47:0] th,
                             logic [47:0] wt);
        write_reg(REG_SHORT_WIN, sw);
        write_reg(REG_LONG_WIN, lw);
        write_reg(REG_LC_WARN, lcw);
        write_reg(REG_HD_WARN, hdw);
        write_reg(REG_REC_HOLD, rh);
        write_reg(REG_THRESH, th);
        write_reg(REG_WEIGHTS, wt);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic frc_in_t make_frame(logic [47:0] ts, logic [4:0] flags,
                                           logic [23:0] dur);
        frc_in_t f;
        f.frame_time_ms = ts;
        {f.eyes_shut, f.eyes_shut_long, f.yawn, f.head_low, f.face_seen} = flags;
        f.closure_duration_ms = dur;
        f.long_closure_duration_ms = dur;
        f.yawn_len_ms = dur;
        f.head_low_len_ms = dur;
        return f;
    endfunction

    function automatic logic [23:0] rand_dur();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 6000));
            1: return 24'($urandom_range(0, 70000));
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 2000));
        endcase
    endfunction

    // Flags persist across frames and toggle now and then, so edges come and go
    task automatic queue_random(int n, int max_step);
        frc_in_t f;
        f = '0;
        f.face_seen = 1'b1;
        for (int i = 0; i < n; i++) begin
            ts_now = ts_now + $urandom_range(0, max_step);
            f.frame_time_ms = ts_now;
            if ($urandom_range(0, 3) == 0) f.eyes_shut = ~f.eyes_shut;
            if ($urandom_range(0, 4) == 0) f.eyes_shut_long = ~f.eyes_shut_long;
            if ($urandom_range(0, 3) == 0) f.yawn = ~f.yawn;
            if ($urandom_range(0, 4) == 0) f.head_low = ~f.head_low;
            f.face_seen = ($urandom_range(0, 9) != 0);
            f.closure_duration_ms = rand_dur();
            f.long_closure_duration_ms = rand_dur();
            f.yawn_len_ms = rand_dur();
            f.head_low_len_ms = rand_dur();
            frame_q.push_back(f);
        end
    endtask

    // Wait until every queued frame is taken and every result has come back
    task automatic drain();
        while (frame_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        win_short = SHORT_WIN_RST; win_long = LONG_WIN_RST;
        lc_warn = LC_WARN_RST; hd_warn = HD_WARN_RST; hold_ms = REC_HOLD_RST;
        thr_reg = THRESH_RST; wgt_reg = WEIGHTS_RST;
        wr_ptr = 0; fill_cnt = 0; held_lvl = LVL_NORMAL; score_acc = 0;
        recov = 0; rec_start = '0; last_decay = '0; prev_flags = '0;
        ts_now = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero timestamps keep the decay timer unstarted
        frame_q.push_back(make_frame(48'd0, 5'b00001, 24'd0));
        frame_q.push_back(make_frame(48'd0, 5'b11111, 24'hFFFFFF));
        frame_q.push_back(make_frame(48'd0, 5'b00000, 24'd0));
        // closure together with long closure
        frame_q.push_back(make_frame(48'd500, 5'b11001, 24'd1500));
        frame_q.push_back(make_frame(48'd1500, 5'b00001, 24'd0));
        frame_q.push_back(make_frame(48'd2600, 5'b10001, 24'd10));
        frame_q.push_back(make_frame(48'd2700, 5'b00101, 24'd300));
        frame_q.push_back(make_frame(48'd2800, 5'b00011, 24'd3000));
        frame_q.push_back(make_frame(48'd2900, 5'b01001, 24'd1499));
        // time going backwards
        frame_q.push_back(make_frame(48'd1000, 5'b10101, 24'd5));
        frame_q.push_back(make_frame(48'd900, 5'b00001, 24'd0));
        // face lost with no flag, then quiet frames through the hold time
        frame_q.push_back(make_frame(48'd4000, 5'b00000, 24'd0));
        frame_q.push_back(make_frame(48'd9500, 5'b00001, 24'd0));
        frame_q.push_back(make_frame(48'd15000, 5'b00001, 24'd0));
        frame_q.push_back(make_frame(48'd400000, 5'b00001, 24'hFFFFFF));
        frame_q.push_back(make_frame(48'd400000, 5'b01111, 24'hFFFFFF));
        frame_q.push_back(make_frame(48'd401000, 5'b00000, 24'd0));
        ts_now = 48'd401000;
        drain();

        // Defaults, random traffic
        queue_random(150, 3000);
        drain();
        // Short windows, small thresholds; unused index is ignored
        write_reg(REG_UNUSED, rand48());
        write_all(2000, 8000, 500, 800, 1500, {8'd3, 8'd6, 8'd4, 8'd3, 8'd2, 8'd1},
                  {8'd2, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6});
        queue_random(150, 800);
        drain();
        // All ones
        write_all('1, '1, '1, '1, '1, '1, '1);
        queue_random(120, 3000);
        drain();
        // All zeros
        write_all('0, '0, '0, '0, '0, '0, '0);
        queue_random(120, 3000);
        drain();
        // Random register values, twice
        repeat (2) begin
            write_all(rand48(), rand48(), rand48(), rand48(), rand48(),
                      {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom),
                       5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)},
                      rand48());
            queue_random(100, 2500);
            drain();
        end
        // Timestamps near the top of the range
        write_all(SHORT_WIN_RST, LONG_WIN_RST, LC_WARN_RST, HD_WARN_RST, REC_HOLD_RST,
                  THRESH_RST, WEIGHTS_RST);
        ts_now = 48'hFFFF_FFF0_0000;
        queue_random(150, 3000);
        drain();

        repeat (200) @(posedge aclk);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/frc_pkg.sv
hdl/frc_ring.sv
hdl/fatigue_risk_classifier.sv
hdl/frc_checker.sv
sim/tb_fatigue_risk_classifier.sv
